// ----- hdl/cstp_pkg.sv -----
// Shared types, codes and default sizes for the call-stack exclusive-time profiler.
`timescale 1ns / 1ps

package cstp_pkg;

    localparam int NUM_FUNCS_DEF   = 64;
    localparam int STACK_DEPTH_DEF = 64;

    localparam int OP_W    = 2;
    localparam int ID_W    = 6;
    localparam int TS_W    = 32;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 33;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] mark;
    } stack_entry_t;

    typedef struct packed {
        status_t            status;
        logic [TOTAL_W-1:0] total;
    } out_beat_t;

endpackage

// ----- hdl/cstp_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module cstp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/call_stack_exclusive_time_profiler.sv -----
// Call-stack exclusive-time profiler top level.
// Usage: each s_ beat carries one trace event (s_opcode start, end, read total or
// no-op, s_func_id, s_timestamp). Every accepted beat yields exactly one m_ beat
// with m_status (ok, stack overflow, end on empty stack, end id mismatch) and
// m_total_time (the function's exclusive total on a read, else zero).
// Throughput: one beat per cycle while s_ready is high. The stack top and the entry below it sit in
// registers, deeper entries in a stack RAM; per-function totals sit in a totals
// RAM updated read-modify-write, with forwarding of the write of the previous
// cycle.
// Each result is registered in stage s1, then written to the result queue that drives m_.
// Reset: the call stack empties at once; then a clearing pass zeroes the totals
// RAM, one entry per cycle over all NUM_FUNCS entries, with s_ready held low.
// Receiver stall: a three-entry result queue keeps accepting while m_ready is
// low; s_ready drops only once the queue and the beat in flight fill it.
`timescale 1ns / 1ps

module call_stack_exclusive_time_profiler
    import cstp_pkg::*;
#(
    parameter int NUM_FUNCS   = NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_opcode,
    input  logic [ID_W-1:0]    s_func_id,
    input  logic [TS_W-1:0]    s_timestamp,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAT_W-1:0]  m_status,
    output logic [TOTAL_W-1:0] m_total_time
);

    localparam int FAW  = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int SEW  = ID_W + TS_W;
    localparam int OBW  = STAT_W + TOTAL_W;

    // ---------------- stack state ----------------
    logic [CW-1:0]  count_reg, count_next;
    stack_entry_t   top_reg, top_next;
    stack_entry_t   second_reg, second_next, second_cur;
    logic           sec_ram_reg, sec_ram_next;

    logic           stk_we;
    logic [SAW-1:0] stk_waddr;
    stack_entry_t   stk_wdata;
    logic [SAW-1:0] stk_raddr;
    logic [SEW-1:0] stk_rdata;

    // ---------------- totals pipeline ----------------
    logic                s1_valid_reg, s1_valid_next;
    logic [FAW-1:0]      s1_addr_reg, s1_addr_next;
    logic                s1_credit_reg, s1_credit_next;
    logic                s1_read_reg, s1_read_next;
    logic [TOTAL_W-1:0]  s1_amount_reg, s1_amount_next;
    status_t             s1_status_reg, s1_status_next;

    logic                fwd_valid_reg;
    logic [FAW-1:0]      fwd_addr_reg;
    logic [TOTAL_W-1:0]  fwd_data_reg;

    logic                clearing_reg;
    logic [FAW-1:0]      clr_cnt_reg;

    logic                tot_we;
    logic [FAW-1:0]      tot_waddr;
    logic [TOTAL_W-1:0]  tot_wdata;
    logic [FAW-1:0]      tot_raddr;
    logic [TOTAL_W-1:0]  tot_rdata;
    logic [TOTAL_W-1:0]  tot_old;
    logic [TOTAL_W:0]    tot_sum;
    logic [TOTAL_W-1:0]  tot_new;
    logic                credit_we;

    // ---------------- result queue ----------------
    logic [OBW-1:0] q_mem [3];
    logic [1:0]     q_head_reg, q_tail_reg, q_cnt_reg;
    logic           q_push, q_pop;
    out_beat_t      q_in, q_out;

    // ---------------- input decode ----------------
    logic               accept;
    logic               ts_ge_mark;
    logic [TOTAL_W-1:0] diff;
    logic [TS_W-1:0]    ts_plus1;
    logic               top_id_ok, in_id_ok;

    assign accept     = s_valid && s_ready;
    assign second_cur = sec_ram_reg ? stack_entry_t'(stk_rdata) : second_reg;
    assign ts_ge_mark = s_timestamp >= top_reg.mark;
    assign diff       = {1'b0, s_timestamp} - {1'b0, top_reg.mark};
    assign ts_plus1   = (s_timestamp == {TS_W{1'b1}}) ? s_timestamp : s_timestamp + 1'b1;
    assign top_id_ok  = 32'(top_reg.id) < NUM_FUNCS;
    assign in_id_ok   = 32'(s_func_id) < NUM_FUNCS;

    always_comb begin
        count_next     = count_reg;
        top_next       = top_reg;
        second_next    = second_cur;
        sec_ram_next   = 1'b0;
        stk_we         = 1'b0;
        stk_waddr      = SAW'(count_reg - CW'(2));
        stk_wdata      = second_cur;
        stk_raddr      = SAW'(count_reg - CW'(3));
        s1_valid_next  = accept;
        s1_addr_next   = FAW'(s_func_id);
        s1_credit_next = 1'b0;
        s1_read_next   = 1'b0;
        s1_amount_next = diff;
        s1_status_next = ST_OK;

        if (accept) begin
            unique case (opcode_t'(s_opcode))
                OP_START: begin
                    if (count_reg >= CW'(STACK_DEPTH)) begin
                        s1_status_next = ST_OVERFLOW;
                    end else begin
                        top_next   = '{id: s_func_id, mark: s_timestamp};
                        count_next = count_reg + 1'b1;
                        if (count_reg != '0) begin
                            // charge the interrupted function, then demote it
                            s1_addr_next   = FAW'(top_reg.id);
                            s1_credit_next = ts_ge_mark && top_id_ok;
                            second_next    = '{id: top_reg.id, mark: s_timestamp};
                            stk_we         = count_reg >= CW'(2);
                        end
                    end
                end
                OP_END: begin
                    if (count_reg == '0) begin
                        s1_status_next = ST_EMPTY;
                    end else begin
                        if (top_reg.id != s_func_id) begin
                            s1_status_next = ST_MISMATCH;
                        end
                        s1_credit_next = ts_ge_mark && in_id_ok;
                        s1_amount_next = diff + 1'b1;
                        count_next     = count_reg - 1'b1;
                        if (count_reg >= CW'(2)) begin
                            top_next = '{id: second_cur.id, mark: ts_plus1};
                        end
                        // new second arrives from the stack RAM next cycle
                        sec_ram_next = count_reg >= CW'(3);
                    end
                end
                OP_READ: begin
                    s1_read_next = in_id_ok;
                end
                OP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    cstp_ram #(
        .WIDTH(SEW),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .aclk (aclk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    // ---------------- totals read-modify-write ----------------
    assign tot_raddr = s1_addr_next;
    assign tot_old   = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : tot_rdata;
    assign tot_sum   = {1'b0, tot_old} + {1'b0, s1_amount_reg};
    assign tot_new   = tot_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_sum[TOTAL_W-1:0];
    assign credit_we = s1_valid_reg && s1_credit_reg;

    always_comb begin
        if (clearing_reg) begin
            tot_we    = 1'b1;
            tot_waddr = clr_cnt_reg;
            tot_wdata = '0;
        end else begin
            tot_we    = credit_we;
            tot_waddr = s1_addr_reg;
            tot_wdata = tot_new;
        end
    end

    cstp_ram #(
        .WIDTH(TOTAL_W),
        .DEPTH(NUM_FUNCS)
    ) u_totals_ram (
        .aclk (aclk),
        .we   (tot_we),
        .waddr(tot_waddr),
        .wdata(tot_wdata),
        .raddr(tot_raddr),
        .rdata(tot_rdata)
    );

    // ---------------- result queue ----------------
    assign q_push = s1_valid_reg;
    assign q_pop  = m_valid && m_ready;
    assign q_in   = '{status: s1_status_reg, total: s1_read_reg ? tot_old : '0};
    assign q_out  = out_beat_t'(q_mem[q_head_reg]);

    assign m_valid      = q_cnt_reg != 2'd0;
    assign m_status     = q_out.status;
    assign m_total_time = q_out.total;
    assign s_ready      = !clearing_reg
                          && (({1'b0, q_cnt_reg} + {2'b00, s1_valid_reg}) < 3'd3);

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            sec_ram_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            q_head_reg    <= '0;
            q_tail_reg    <= '0;
            q_cnt_reg     <= '0;
        end else begin
            count_reg     <= count_next;
            sec_ram_reg   <= sec_ram_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= credit_we;
            if (clearing_reg) begin
                if (clr_cnt_reg == FAW'(NUM_FUNCS - 1)) begin
                    clearing_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (q_push) begin
                q_tail_reg <= (q_tail_reg == 2'd2) ? 2'd0 : q_tail_reg + 2'd1;
            end
            if (q_pop) begin
                q_head_reg <= (q_head_reg == 2'd2) ? 2'd0 : q_head_reg + 2'd1;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, q_pop};
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        top_reg       <= top_next;
        second_reg    <= second_next;
        s1_addr_reg   <= s1_addr_next;
        s1_credit_reg <= s1_credit_next;
        s1_read_reg   <= s1_read_next;
        s1_amount_reg <= s1_amount_next;
        s1_status_reg <= s1_status_next;
        fwd_addr_reg  <= s1_addr_reg;
        fwd_data_reg  <= tot_new;
        if (q_push) begin
            q_mem[q_tail_reg] <= q_in;
        end
    end

endmodule

// ----- test/call_stack_exclusive_time_profiler_test.sv -----
// Self-checking testbench for the call-stack exclusive-time profiler.
`timescale 1ns / 1ps

module call_stack_exclusive_time_profiler_test;
    import cstp_pkg::*;

    class profile_scoreboard;
        logic [ID_W-1:0]    frame_id[STACK_DEPTH_DEF];
        logic [TS_W-1:0]    frame_mark[STACK_DEPTH_DEF];
        int                 depth;
        logic [TOTAL_W-1:0] fn_total[NUM_FUNCS_DEF];
        out_beat_t          pending_results[$];
        int                 errors;

        function new();
            depth  = 0;
            errors = 0;
            foreach (fn_total[i]) fn_total[i] = '0;
        endfunction

        // Saturate at the top of the total range.
        function void add_time(logic [ID_W-1:0] id, logic [TS_W:0] amount);
            logic [TOTAL_W:0] sum;
            if (int'(id) < NUM_FUNCS_DEF) begin
                sum = {1'b0, fn_total[id]} + amount;
                if (sum[TOTAL_W]) fn_total[id] = '1;
                else fn_total[id] = sum[TOTAL_W-1:0];
            end
        endfunction

        function void note_event(opcode_t op, logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
            out_beat_t       res;
            logic [TS_W-1:0] mark;
            res.status = ST_OK;
            res.total  = '0;
            case (op)
                OP_START: begin
                    if (depth >= STACK_DEPTH_DEF) begin
                        res.status = ST_OVERFLOW;
                    end else begin
                        if (depth > 0) begin
                            mark = frame_mark[depth-1];
                            if (ts >= mark) add_time(frame_id[depth-1], {1'b0, ts - mark});
                            frame_mark[depth-1] = ts;
                        end
                        frame_id[depth]   = id;
                        frame_mark[depth] = ts;
                        depth++;
                    end
                end
                OP_END: begin
                    if (depth == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        mark = frame_mark[depth-1];
                        if (frame_id[depth-1] != id) res.status = ST_MISMATCH;
                        // The given id is credited even when it differs from the top.
                        if (ts >= mark) add_time(id, {1'b0, ts - mark} + 33'd1);
                        depth--;
                        if (depth > 0) frame_mark[depth-1] = (ts == '1) ? ts : ts + 32'd1;
                    end
                end
                OP_READ: begin
                    if (int'(id) < NUM_FUNCS_DEF) res.total = fn_total[id];
                end
                default: ;
            endcase
            pending_results = {pending_results, res};
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        task check_result(logic [STAT_W-1:0] st, logic [TOTAL_W-1:0] tot);
            out_beat_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected beat status=%0d total=%h", st, tot));
            end else begin
                want = pending_results.pop_front();
                if (st !== want.status)
                    report($sformatf("status %0d, want %0d", st, want.status));
                if (tot !== want.total)
                    report($sformatf("total_time %h, want %h", tot, want.total));
            end
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [OP_W-1:0]    s_opcode;
    logic [ID_W-1:0]    s_func_id;
    logic [TS_W-1:0]    s_timestamp;
    logic               m_valid;
    logic               m_ready;
    logic [STAT_W-1:0]  m_status;
    logic [TOTAL_W-1:0] m_total_time;

    profile_scoreboard sb;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                stall_left;
    int                events_sent;
    logic [TS_W-1:0]   trace_clock;

    call_stack_exclusive_time_profiler uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_func_id    (s_func_id),
        .s_timestamp  (s_timestamp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_total_time (m_total_time)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: a long hold-off counts down here, otherwise random idling.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_status, m_total_time);
    end

    initial begin
        #3_000_000;
        $display("call_stack_exclusive_time_profiler test failed");
        $finish;
    end

    // Entered and left at a falling edge; valid is touched once per step.
    task automatic send_event(opcode_t op, logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_func_id   <= id;
        s_timestamp <= ts;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(op, id, ts);
        events_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending_results.size() != 0);
    endtask

    // Mostly small steps, now and then a big jump or a stamp before the mark.
    function automatic logic [TS_W-1:0] next_stamp();
        int r;
        r = $urandom_range(99);
        if (r < 2) trace_clock += $urandom;
        else if (r < 7) return trace_clock - $urandom_range(1, 40);
        else trace_clock += $urandom_range(0, 12);
        return trace_clock;
    endfunction

    task automatic nested_calls(int len);
        int              r;
        logic [TS_W-1:0] ts;
        for (int k = 0; k < len; k++) begin
            r  = $urandom_range(99);
            ts = next_stamp();
            if (sb.depth == 0 || r < (sb.depth > 12 ? 20 : 45))
                send_event(OP_START, ID_W'($urandom_range(63)), ts);
            else if (r < 82)
                send_event(OP_END, sb.frame_id[sb.depth-1], ts);
            else if (r < 92)
                send_event(OP_READ, ID_W'($urandom_range(63)), ts);
            else if (r < 96)
                send_event(OP_END, ID_W'($urandom_range(63)), ts);
            else
                send_event(OP_NOP, ID_W'($urandom_range(63)), ts);
        end
    endtask

    // Fill the stack past its depth, then unwind it in order.
    task automatic deep_recursion();
        int extra;
        extra = $urandom_range(1, 3);
        while (sb.depth < STACK_DEPTH_DEF)
            send_event(OP_START, ID_W'($urandom_range(63)), next_stamp());
        repeat (extra) send_event(OP_START, ID_W'($urandom_range(63)), next_stamp());
        while (sb.depth > 0)
            send_event(OP_END, sb.frame_id[sb.depth-1], next_stamp());
        send_event(OP_READ, ID_W'($urandom_range(63)), next_stamp());
    endtask

    task automatic random_events(int len);
        repeat (len)
            send_event(opcode_t'($urandom_range(3)), ID_W'($urandom_range(63)), $urandom);
    endtask

    task automatic run_traffic(int target);
        int r;
        while (events_sent < target) begin
            r = $urandom_range(99);
            if (r < 4) deep_recursion();
            else if (r < 80) nested_calls($urandom_range(5, 40));
            else random_events($urandom_range(1, 8));
        end
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_opcode      = OP_NOP;
        s_func_id     = '0;
        s_timestamp   = '0;
        m_ready       = 1'b0;
        stall_left    = 0;
        events_sent   = 0;
        trace_clock   = '0;
        send_idle_pct = 26;
        recv_idle_pct = 53;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Empty stack, idle opcode, a read of an untouched total.
        send_event(OP_END, 6'd0, 32'd0);
        send_event(OP_READ, 6'd63, 32'd0);
        send_event(OP_NOP, 6'd63, 32'hFFFF_FFFF);
        // Stamp before the mark, then an end whose id differs from the top.
        send_event(OP_START, 6'd1, 32'd10);
        send_event(OP_START, 6'd2, 32'd5);
        send_event(OP_END, 6'd3, 32'd20);
        send_event(OP_END, 6'd1, 32'd15);
        send_event(OP_READ, 6'd1, 32'd15);
        send_event(OP_READ, 6'd3, 32'd15);
        send_event(OP_READ, 6'd2, 32'd15);
        // Two full-range calls push the total into saturation.
        repeat (2) begin
            send_event(OP_START, 6'd63, 32'd0);
            send_event(OP_END, 6'd63, 32'hFFFF_FFFF);
        end
        send_event(OP_READ, 6'd63, 32'hFFFF_FFFF);
        // End at the last tick: the caller's mark pins at the top.
        send_event(OP_START, 6'd0, 32'd0);
        send_event(OP_START, 6'd62, 32'd100);
        send_event(OP_END, 6'd62, 32'hFFFF_FFFF);
        send_event(OP_END, 6'd0, 32'hFFFF_FFFF);
        send_event(OP_READ, 6'd0, 32'hFFFF_FFFF);
        send_event(OP_READ, 6'd62, 32'hFFFF_FFFF);

        trace_clock = '0;
        run_traffic(450);
        wait_results_drained();

        send_idle_pct = 53;
        recv_idle_pct = 26;
        run_traffic(890);
        wait_results_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left   <= 300;
        run_traffic(1320);
        wait_results_drained();

        repeat (8) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("call_stack_exclusive_time_profiler test passed");
        end else begin
            $display("call_stack_exclusive_time_profiler test failed");
        end
        $finish;
    end

endmodule
